[rtl/sha_pkg.sv]
`default_nettype none
// ============================================================================
// SHA-256 hasher package
// Shared types, round constants, initial hash values and command struct.
// ============================================================================
package sha_pkg;

    typedef logic [31:0] word_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // One queued command from the front part to the compression engine.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } eng_state_t;

    function automatic word_t init_h(input logic [2:0] idx);
        word_t r;
        unique case (idx)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic word_t round_k(input logic [5:0] idx);
        word_t r;
        unique case (idx)
            6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
            6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
            6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
            6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
            6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
            6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/sha_queue.sv]
`default_nettype none
// ============================================================================
// SHA-256 command queue
// Small FIFO that decouples the input side from the compression engine.
// ============================================================================
module sha_queue #(
    parameter int DEPTH = 4
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              in_valid,
    output logic             in_ready,
    input  sha_pkg::cmd_t    in_cmd,
    output logic             out_valid,
    input  wire              out_ready,
    output sha_pkg::cmd_t    out_cmd
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha_pkg::cmd_t          mem_reg [DEPTH];
    logic [AW-1:0]          wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]            count_reg;
    logic                   push, pop;

    assign in_ready  = (count_reg != (AW+1)'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Storage write.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

[rtl/sha_engine.sv]
`default_nettype none
// ============================================================================
// SHA-256 compression engine
// Buffers bytes, runs one round a cycle, pads the last block, emits digest.
// ============================================================================
module sha_engine (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              cmd_valid,
    output logic             cmd_ready,
    input  sha_pkg::cmd_t    cmd,
    output logic             out_valid,
    input  wire              out_ready,
    output logic [63:0]      out_word,
    output logic [1:0]       out_index,
    output logic             out_last
);
    sha_pkg::eng_state_t state_reg, state_next;

    sha_pkg::word_t h_reg [8];
    sha_pkg::word_t v_reg [8];
    sha_pkg::word_t w_reg [16];     // sliding message schedule window
    logic [60:0]    count_reg;
    logic [5:0]     round_reg;
    logic           fin_reg;        // the running block ends the message
    logic           last_blk_reg;   // the running block holds the length
    logic           len_pend_reg;   // a second padding block must follow
    logic [1:0]     emit_reg;

    logic [5:0]     pos;
    logic           take;
    sha_pkg::word_t wcur, s0w, s1w, wnew, t1, t2, e, a;
    logic [63:0]    bits;

    assign pos  = count_reg[5:0];
    assign bits = {count_reg, 3'b000};
    assign take = cmd_valid && cmd_ready;
    assign wcur = w_reg[0];
    assign a    = v_reg[0];
    assign e    = v_reg[4];

    // Round datapath and schedule expansion.
    always_comb begin
        s0w  = {w_reg[1][6:0], w_reg[1][31:7]} ^ {w_reg[1][17:0], w_reg[1][31:18]}
             ^ (w_reg[1] >> 3);
        s1w  = {w_reg[14][16:0], w_reg[14][31:17]} ^ {w_reg[14][18:0], w_reg[14][31:19]}
             ^ (w_reg[14] >> 10);
        wnew = s1w + w_reg[9] + s0w + w_reg[0];
        t1   = v_reg[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
             + ((e & v_reg[5]) ^ (~e & v_reg[6])) + sha_pkg::round_k(round_reg) + wcur;
        t2   = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
             + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sha_pkg::ST_IDLE: begin
                if (take) begin
                    if (cmd.byte_valid && pos == 6'd63) begin
                        state_next = sha_pkg::ST_ROUND;
                    end else if (cmd.end_of_message) begin
                        state_next = sha_pkg::ST_ROUND;
                    end
                end
            end
            sha_pkg::ST_ROUND: if (round_reg == 6'd63) state_next = sha_pkg::ST_FOLD;
            sha_pkg::ST_FOLD: begin
                if (last_blk_reg) begin
                    state_next = sha_pkg::ST_EMIT;
                end else if (fin_reg) begin
                    state_next = sha_pkg::ST_PAD;
                end else begin
                    state_next = sha_pkg::ST_IDLE;
                end
            end
            sha_pkg::ST_PAD: state_next = sha_pkg::ST_ROUND;
            sha_pkg::ST_EMIT: begin
                if (out_ready && emit_reg == 2'd3) state_next = sha_pkg::ST_IDLE;
            end
            default: state_next = sha_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        cmd_ready = (state_reg == sha_pkg::ST_IDLE);
        out_valid = (state_reg == sha_pkg::ST_EMIT);
        out_word  = {h_reg[{emit_reg, 1'b0}], h_reg[{emit_reg, 1'b1}]};
        out_index = emit_reg;
        out_last  = (emit_reg == 2'd3);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sha_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) h_reg[i] <= sha_pkg::init_h(3'(i));
            count_reg    <= '0;
            round_reg    <= '0;
            fin_reg      <= 1'b0;
            last_blk_reg <= 1'b0;
            len_pend_reg <= 1'b0;
            emit_reg     <= '0;
        end else begin
            unique case (state_reg)
                sha_pkg::ST_IDLE: begin
                    if (take) begin
                        logic [5:0] p;
                        logic [31:0] wv;
                        p = pos;
                        wv = w_reg[p[5:2]];
                        if (cmd.byte_valid) begin
                            wv[8*(3-p[1:0]) +: 8] = cmd.data_byte;
                            // On a finish inside the block, the padding pass writes this word.
                            if (!cmd.end_of_message || p == 6'd63) begin
                                w_reg[p[5:2]] <= wv;
                            end
                            count_reg <= count_reg + 61'd1;
                        end
                        fin_reg <= cmd.end_of_message;
                        round_reg <= '0;
                        for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                        if (cmd.end_of_message && !(cmd.byte_valid && p == 6'd63)) begin
                            logic [5:0]  q;
                            logic [60:0] c;
                            logic [63:0] b;
                            q = cmd.byte_valid ? p + 6'd1 : p;
                            c = cmd.byte_valid ? count_reg + 61'd1 : count_reg;
                            b = {c, 3'b000};
                            // Pad the current block: 0x80, zeros, maybe the length.
                            for (int j = 0; j < 16; j++) begin
                                logic [31:0] ww;
                                ww = (j == int'(p[5:2])) ? wv : w_reg[j];
                                for (int k = 0; k < 4; k++) begin
                                    if (6'(4*j+k) == q) begin
                                        ww[8*(3-k) +: 8] = sha_pkg::PAD_BYTE;
                                    end else if (6'(4*j+k) > q) begin
                                        ww[8*(3-k) +: 8] = 8'h00;
                                    end
                                end
                                if (q < 6'd56) begin
                                    if (j == 14) ww = b[63:32];
                                    if (j == 15) ww = b[31:0];
                                end
                                w_reg[j] <= ww;
                            end
                            last_blk_reg <= (q < 6'd56);
                            len_pend_reg <= (q >= 6'd56);
                        end else begin
                            last_blk_reg <= 1'b0;
                            len_pend_reg <= 1'b0;
                        end
                    end
                end
                sha_pkg::ST_ROUND: begin
                    v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    for (int j = 0; j < 15; j++) w_reg[j] <= w_reg[j+1];
                    w_reg[15] <= wnew;
                    round_reg <= round_reg + 6'd1;
                end
                sha_pkg::ST_FOLD: begin
                    for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                    emit_reg <= '0;
                end
                sha_pkg::ST_PAD: begin
                    // Second block: 0x80 may be here when the first ended full.
                    for (int j = 1; j < 14; j++) w_reg[j] <= '0;
                    w_reg[0] <= len_pend_reg ? '0 : {sha_pkg::PAD_BYTE, 24'h0};
                    w_reg[14] <= bits[63:32];
                    w_reg[15] <= bits[31:0];
                    last_blk_reg <= 1'b1;
                    round_reg    <= '0;
                    for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                end
                sha_pkg::ST_EMIT: begin
                    if (out_ready) begin
                        emit_reg <= emit_reg + 2'd1;
                        if (emit_reg == 2'd3) begin
                            for (int i = 0; i < 8; i++) h_reg[i] <= sha_pkg::init_h(3'(i));
                            count_reg <= '0;
                            fin_reg   <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/sha256_byte_stream_hasher.sv]
`default_nettype none
// ============================================================================
// SHA-256 byte stream hasher
// Hashes a byte stream one byte per transaction and emits a 256-bit digest.
// ============================================================================
// Channel  Direction  tdata                 tuser
// s_       in         data_byte[7:0]        {end_of_message, byte_valid}
// m_       out        digest_word[63:0]     word_index[1:0]; tlast = last_word
//
// The engine stores a byte while it is idle; every 64th byte starts a
// compression (one round per cycle) followed by a fold step.
// A finishing transaction costs one or two compressions, then four digest
// transactions. Reset brings the initial hash values and a zero count.
// A queue of QUEUE_DEPTH entries (four by default) lets the input side accept while the engine is busy.
// ============================================================================
module sha256_byte_stream_hasher #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // data_byte
    input  wire  [1:0]  s_tuser,   // end_of_message, byte_valid
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [63:0] m_tdata,   // digest_word
    output logic [1:0]  m_tuser,   // word_index
    output logic        m_tlast
);
    sha_pkg::cmd_t in_cmd, q_cmd;
    logic          q_valid, q_ready;

    // Classify the incoming transaction into a command.
    always_comb begin
        in_cmd.data_byte      = s_tdata;
        in_cmd.byte_valid     = s_tuser[0];
        in_cmd.end_of_message = s_tuser[1];
    end

    sha_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid && (s_tuser[0] || s_tuser[1])),
        .in_ready  (s_tready),
        .in_cmd    (in_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    sha_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (m_tdata),
        .out_index (m_tuser),
        .out_last  (m_tlast)
    );
endmodule
`default_nettype wire
